// File: design/rngst_pkg.sv
// ============================================================================
// rngst_pkg
// Shared constants and types for the key statistics block: report layout,
// counter widths and saturation limits.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package rngst_pkg;

  // Key geometry and run binning
  localparam int KEY_NIBBLES = 5000;
  localparam int RUN_BINS    = 6;
  localparam int RIDX_W      = $clog2(2 * RUN_BINS);

  // Report layout
  localparam int NUM_STATS = 21 + 2 * RUN_BINS;
  localparam int IDX_ONES  = 0;
  localparam int IDX_HIST  = 1;
  localparam int IDX_SUMSQ = 17;
  localparam int IDX_POKER = 18;
  localparam int IDX_RUNS  = 19;
  localparam int IDX_LONG  = IDX_RUNS + 2 * RUN_BINS;
  localparam int CNT_W     = $clog2(NUM_STATS + 1);

  // Counter limits
  localparam logic [14:0] CNT15_MAX  = 15'h7FFF;
  localparam logic [12:0] CNT13_MAX  = 13'h1FFF;
  localparam logic [24:0] SUMSQ_MAX  = 25'h1FF_FFFF;
  localparam logic [14:0] THR_RESET  = 15'd34;
  localparam logic [31:0] POKER_BIAS = 32'(KEY_NIBBLES * KEY_NIBBLES);

  typedef logic [14:0]        cnt15_t;
  typedef logic [12:0]        cnt13_t;
  typedef logic [24:0]        sumsq_t;
  typedef logic [5:0]         stat_idx_t;
  typedef logic signed [29:0] stat_val_t;

  // Saturating add of a small amount to a 15-bit counter
  function automatic cnt15_t sat_add15(cnt15_t v, logic [2:0] n);
    logic [15:0] s;
    s = {1'b0, v} + 16'(n);
    return s[15] ? CNT15_MAX : s[14:0];
  endfunction

endpackage

`default_nettype wire

// File: design/rng_statistical_test_suite.sv
// ============================================================================
// rng_statistical_test_suite
// Monobit, poker, runs and long-run statistics over a key that arrives as
// ASCII hex characters; a 33-entry report goes out at each key end.
// ============================================================================
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, in_hex_char, in_key_end | input
//  out     | out_valid/out_ready, out_stat_index,    | output
//          | out_stat_value, out_last_stat           |
//  cfg     | cfg_wr_en, cfg_wr_data (run threshold)  | input
//
//  One character per cycle is taken unless a key end waits. A character is
//  held in the input register and folded into the counters in the next
//  cycle, unless it is a waiting key end. At key end the report is captured
//  into a shift line that drains one result per cycle while out_ready is high.
//  A key end waits in the input register while the old report holds more than
//  its final result or that result stalls; other characters keep flowing.
//  Synchronous active-low reset clears all counters; the threshold resets to 34.
`timescale 1ns / 1ps
`default_nettype none

module rng_statistical_test_suite (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [7:0]            in_hex_char,
  input  wire                   in_key_end,
  output logic                  out_valid,
  input  wire                   out_ready,
  output rngst_pkg::stat_idx_t  out_stat_index,
  output rngst_pkg::stat_val_t  out_stat_value,
  output logic                  out_last_stat,
  input  wire                   cfg_wr_en,
  input  wire  [14:0]           cfg_wr_data
);
  import rngst_pkg::*;

  // Input register
  logic       vld_r;
  logic [7:0] chr_r;
  logic       end_r;

  // Statistics state
  cnt15_t thr_r;
  cnt15_t ones_r;
  cnt13_t hist_r [16];
  sumsq_t sumsq_r;
  logic   bit_r;
  cnt15_t len_r;
  cnt15_t runh_r [2*RUN_BINS];
  cnt15_t long_r [2];

  // Report shift line
  stat_val_t        snap_r [NUM_STATS];
  logic [CNT_W-1:0] cnt_r;
  stat_idx_t        idx_r;

  // Updated values
  logic        digit;
  logic [3:0]  nib;
  cnt13_t      hc;
  logic [25:0] ssum;
  cnt15_t      ones_u;
  sumsq_t      sumsq_u;
  cnt13_t      hist_u [16];
  logic        bit_v;
  cnt15_t      len_v;
  logic [RIDX_W-1:0] ridx;
  logic [RIDX_W-1:0] bin;
  logic        do_close;
  logic [2:0]  rhits [2*RUN_BINS];
  logic [2:0]  lhits [2];
  cnt15_t      runh_u [2*RUN_BINS];
  cnt15_t      long_u [2];
  logic [31:0] poker;
  stat_val_t   snap_ld [NUM_STATS];

  logic snap_free, proc_ok, advance, pop, load;

  // Handshake
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign snap_free = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);
  assign proc_ok   = !end_r || snap_free;
  assign advance   = vld_r && proc_ok;
  assign load      = advance && end_r;
  assign in_ready  = !vld_r || proc_ok;

  // Character decode, poker bin and sum-of-squares update, and monobit count
  always_comb begin
    digit = ((chr_r >= 8'h30) && (chr_r <= 8'h39)) ||
            ((chr_r >= 8'h41) && (chr_r <= 8'h46));
    nib   = (chr_r <= 8'h39) ? 4'(chr_r - 8'h30) : 4'(chr_r - 8'h37);
    hc    = hist_r[nib];
    ssum  = {1'b0, sumsq_r} + {12'd0, hc, 1'b1};
    sumsq_u = sumsq_r;
    if (digit && (hc != CNT13_MAX)) begin
      sumsq_u = ssum[25] ? SUMSQ_MAX : ssum[24:0];
    end
    for (int j = 0; j < 16; j++) begin
      hist_u[j] = hist_r[j];
      if (digit && (nib == 4'(j)) && (hc != CNT13_MAX)) begin
        hist_u[j] = hist_r[j] + 13'd1;
      end
    end
    ones_u = digit ? sat_add15(ones_r, 3'($countones(nib))) : ones_r;
  end

  // Run tracker: four bits MSB first, then the final close at key end.
  // Closed runs are tallied per bin and added once with saturation.
  always_comb begin
    bit_v = bit_r;
    len_v = len_r;
    ridx  = '0;
    bin   = '0;
    do_close = 1'b0;
    for (int j = 0; j < 2*RUN_BINS; j++) rhits[j] = 3'd0;
    lhits[0] = 3'd0;
    lhits[1] = 3'd0;
    for (int k = 0; k < 5; k++) begin
      do_close = 1'b0;
      if (k < 4) begin
        if (digit) begin
          if ((len_v != '0) && (nib[3-k] == bit_v)) begin
            len_v = sat_add15(len_v, 3'd1);
          end else begin
            do_close = 1'b1;
          end
        end
      end else begin
        do_close = end_r;
      end
      if (do_close && (len_v != '0)) begin
        bin  = (len_v >= 15'(RUN_BINS)) ? RIDX_W'(RUN_BINS - 1)
                                        : RIDX_W'(len_v - 15'd1);
        ridx = bit_v ? RIDX_W'(RUN_BINS) + bin : bin;
        for (int j = 0; j < 2*RUN_BINS; j++) begin
          if (ridx == RIDX_W'(j)) rhits[j] = rhits[j] + 3'd1;
        end
        if (len_v >= thr_r) lhits[bit_v] = lhits[bit_v] + 3'd1;
        len_v = '0;
      end
      if (do_close && (k < 4)) begin
        bit_v = nib[3-k];
        len_v = 15'd1;
      end
    end
    for (int j = 0; j < 2*RUN_BINS; j++) runh_u[j] = sat_add15(runh_r[j], rhits[j]);
    long_u[0] = sat_add15(long_r[0], lhits[0]);
    long_u[1] = sat_add15(long_r[1], lhits[1]);
  end

  // Report contents; the poker value always fits the 30-bit range
  always_comb begin
    poker = {3'd0, sumsq_u, 4'd0} - POKER_BIAS;
    snap_ld[IDX_ONES]  = stat_val_t'({15'd0, ones_u});
    for (int j = 0; j < 16; j++) snap_ld[IDX_HIST+j] = stat_val_t'({17'd0, hist_u[j]});
    snap_ld[IDX_SUMSQ] = stat_val_t'({5'd0, sumsq_u});
    snap_ld[IDX_POKER] = stat_val_t'(poker[29:0]);
    for (int j = 0; j < 2*RUN_BINS; j++) snap_ld[IDX_RUNS+j] = stat_val_t'({15'd0, runh_u[j]});
    snap_ld[IDX_LONG]   = stat_val_t'({15'd0, long_u[0]});
    snap_ld[IDX_LONG+1] = stat_val_t'({15'd0, long_u[1]});
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      chr_r <= in_hex_char;
      end_r <= in_key_end;
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // Statistics state: update, or clear after a key end
  always_ff @(posedge clk) begin
    if (!rst_n || load) begin
      ones_r  <= '0;
      sumsq_r <= '0;
      bit_r   <= 1'b0;
      len_r   <= '0;
      for (int j = 0; j < 16; j++) hist_r[j] <= '0;
      for (int j = 0; j < 2*RUN_BINS; j++) runh_r[j] <= '0;
      long_r[0] <= '0;
      long_r[1] <= '0;
    end else if (advance) begin
      ones_r  <= ones_u;
      sumsq_r <= sumsq_u;
      bit_r   <= bit_v;
      len_r   <= len_v;
      for (int j = 0; j < 16; j++) hist_r[j] <= hist_u[j];
      for (int j = 0; j < 2*RUN_BINS; j++) runh_r[j] <= runh_u[j];
      long_r[0] <= long_u[0];
      long_r[1] <= long_u[1];
    end
  end

  // Report shift line control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= CNT_W'(NUM_STATS);
    end else if (pop) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // Report shift line data
  always_ff @(posedge clk) begin
    if (load) begin
      idx_r <= '0;
      for (int i = 0; i < NUM_STATS; i++) snap_r[i] <= snap_ld[i];
    end else if (pop) begin
      idx_r <= idx_r + 6'd1;
      for (int i = 0; i < NUM_STATS - 1; i++) snap_r[i] <= snap_r[i+1];
    end
  end

  assign out_stat_index = idx_r;
  assign out_stat_value = snap_r[0];
  assign out_last_stat  = (cnt_r == CNT_W'(1));

endmodule

`default_nettype wire

// File: design/rngst_checker.sv
// ============================================================================
// rngst_checker
// Port-level checks on the report stream of the key statistics block.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module rngst_checker (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  out_valid,
  input wire                  out_ready,
  input rngst_pkg::stat_idx_t out_stat_index,
  input rngst_pkg::stat_val_t out_stat_value,
  input wire                  out_last_stat
);
  import rngst_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stat_index) &&
    $stable(out_stat_value) && $stable(out_last_stat))
    else $error("stalled result changed");

  // Results of one report follow each other with rising index
  a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_stat |=>
    out_valid && (out_stat_index == $past(out_stat_index) + 6'd1))
    else $error("report index out of sequence");

  // The final flag marks the last statistic
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_stat == (out_stat_index == 6'(NUM_STATS - 1))))
    else $error("last flag misplaced");

  // Only the poker statistic can be negative
  a_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_stat_index != 6'(IDX_POKER)) |-> !out_stat_value[29])
    else $error("negative counter value");

endmodule

bind rng_statistical_test_suite rngst_checker u_rngst_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_stat_index (out_stat_index),
  .out_stat_value (out_stat_value),
  .out_last_stat  (out_last_stat)
);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - key statistics block testbench
// Streams ASCII hex keys into the block, folds every accepted character into
// a local model of the monobit, poker, runs and long-run counters, and checks
// each 33-entry report against it field by field. Directed keys first, then
// repeated-digit keys and random keys under several run thresholds, with
// random stalls on both channels.
// ============================================================================
module tb;
  import rngst_pkg::*;

  localparam logic [7:0] ASC_0 = "0";
  localparam logic [7:0] ASC_9 = "9";
  localparam logic [7:0] ASC_A = "A";
  localparam logic [7:0] ASC_F = "F";
  localparam logic [7:0] ASC_5 = "5";
  localparam logic [7:0] ASC_X = "x";
  localparam longint VAL_HI = longint'(2 ** 29) - 1;
  localparam longint VAL_LO = -longint'(2 ** 29);
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic [7:0] ch;
    logic       ke;
  } key_char_t;

  typedef struct {
    stat_idx_t idx;
    stat_val_t val;
    logic      last;
  } stat_result_t;

  // Clock and block ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_hex_char = 8'h00;
  logic in_key_end = 1'b0;
  logic out_ready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [14:0] cfg_wr_data = 15'd0;
  logic in_ready;
  logic out_valid;
  stat_idx_t out_stat_index;
  stat_val_t out_stat_value;
  logic out_last_stat;

  always #10 clk = ~clk;

  rng_statistical_test_suite dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_hex_char   (in_hex_char),
    .in_key_end    (in_key_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_stat_index(out_stat_index),
    .out_stat_value(out_stat_value),
    .out_last_stat (out_last_stat),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // Pending requests and predicted report entries
  key_char_t    char_q[$];
  stat_result_t report_q[$];

  int  err_cnt = 0;
  bit  char_taken = 1'b0;
  bit  hold_req = 1'b0;
  bit  no_idle = 1'b0;
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;

  // Local copy of the key statistics
  int unsigned thr_cfg;
  int unsigned ones_cnt;
  int unsigned nib_hist[16];
  int unsigned sq_sum;
  logic        run_val;
  int unsigned run_len;
  int unsigned run_hist[2 * RUN_BINS];
  int unsigned long_runs[2];

  function automatic int unsigned sat15(input int unsigned v);
    return (v < CNT15_MAX) ? v + 1 : CNT15_MAX;
  endfunction

  task automatic clear_key_stats();
    ones_cnt = 0;
    foreach (nib_hist[i]) nib_hist[i] = 0;
    sq_sum = 0;
    run_val = 1'b0;
    run_len = 0;
    foreach (run_hist[i]) run_hist[i] = 0;
    foreach (long_runs[i]) long_runs[i] = 0;
  endtask

  // Bin the finished run and count it as long when it reaches the threshold
  task automatic close_run();
    int bin;
    if (run_len != 0) begin
      bin = (run_len >= RUN_BINS) ? RUN_BINS - 1 : run_len - 1;
      bin = bin + (run_val ? RUN_BINS : 0);
      run_hist[bin] = sat15(run_hist[bin]);
      if (run_len >= thr_cfg) long_runs[run_val] = sat15(long_runs[run_val]);
      run_len = 0;
    end
  endtask

  // Fold one character into the statistics; at key end queue the report
  task automatic predict_char(input logic [7:0] ch, input logic ke);
    int          nib;
    int unsigned c;
    int          k;
    logic        b;
    longint      val;
    stat_result_t r;
    nib = -1;
    if (ch >= ASC_0 && ch <= ASC_9) nib = int'(ch - ASC_0);
    else if (ch >= ASC_A && ch <= ASC_F) nib = int'(ch - ASC_A) + 10;
    if (nib >= 0) begin
      c = nib_hist[nib];
      if (c < CNT13_MAX) begin
        sq_sum = (sq_sum + 2 * c + 1 > SUMSQ_MAX) ? SUMSQ_MAX : sq_sum + 2 * c + 1;
        nib_hist[nib] = c + 1;
      end
      // bits go MSB first through the run tracker
      for (k = 3; k >= 0; k--) begin
        b = nib[k];
        if (b) ones_cnt = sat15(ones_cnt);
        if (run_len != 0 && b == run_val) begin
          run_len = sat15(run_len);
        end else begin
          close_run();
          run_val = b;
          run_len = 1;
        end
      end
    end
    if (ke) begin
      close_run();
      for (k = 0; k < NUM_STATS; k++) begin
        if (k == IDX_ONES) val = ones_cnt;
        else if (k < IDX_SUMSQ) val = nib_hist[k - IDX_HIST];
        else if (k == IDX_SUMSQ) val = sq_sum;
        else if (k == IDX_POKER)
          val = 16 * longint'(sq_sum) - longint'(KEY_NIBBLES) * longint'(KEY_NIBBLES);
        else if (k < IDX_LONG) val = run_hist[k - IDX_RUNS];
        else val = long_runs[k - IDX_LONG];
        if (val > VAL_HI) val = VAL_HI;
        if (val < VAL_LO) val = VAL_LO;
        r.idx  = stat_idx_t'(k);
        r.val  = stat_val_t'(val);
        r.last = (k == NUM_STATS - 1);
        report_q.push_back(r);
      end
      clear_key_stats();
    end
  endtask

  // Character driver: random gaps between requests unless idling is off
  always @(negedge clk) begin : drive_chars
    logic      next_valid;
    key_char_t kc;
    if (rst_n) begin
      next_valid = in_valid && !char_taken;
      char_taken = 1'b0;
      if (!next_valid) begin
        if (no_idle) gap_left = 0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (char_q.size() > 0) begin
          if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 17);
          end else begin
            kc = char_q.pop_front();
            in_hex_char <= kc.ch;
            in_key_end  <= kc.ke;
            next_valid = 1'b1;
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Result receiver: random stall bursts, plus one long hold on request
  always @(negedge clk) begin : drive_ready
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Port monitor: predict on accepted characters, check accepted results
  always @(posedge clk) begin : watch_ports
    stat_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_char(in_hex_char, in_key_end);
        char_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("tb: unexpected result idx %0d val %0d last %0b",
                     out_stat_index, out_stat_value, out_last_stat);
        end else begin
          want = report_q.pop_front();
          if (want.idx !== out_stat_index || want.val !== out_stat_value ||
              want.last !== out_last_stat) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("tb: mismatch want idx %0d val %0d last %0b, got idx %0d val %0d last %0b",
                       want.idx, want.val, want.last,
                       out_stat_index, out_stat_value, out_last_stat);
          end
        end
      end
    end
  end

  task automatic queue_char(input logic [7:0] ch, input logic ke);
    key_char_t kc;
    kc.ch = ch;
    kc.ke = ke;
    char_q.push_back(kc);
  endtask

  // One long key of a single character
  task automatic queue_repeat_key(input logic [7:0] ch, input int n);
    for (int i = 0; i < n; i++) queue_char(ch, i == n - 1);
  endtask

  // Random keys: mostly upper-case hex with bursts of all-zero or all-one
  // digits for long runs, plus arbitrary bytes as noise
  task automatic queue_random_keys(input int n_items);
    int          left;
    int          len;
    int          rep_left;
    int          d;
    logic [7:0]  rep_ch;
    logic [7:0]  ch;
    left = n_items;
    rep_left = 0;
    rep_ch = ASC_0;
    while (left > 0) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 20);
      for (int i = 0; i < len; i++) begin
        if (rep_left == 0 && $urandom_range(0, 5) == 0) begin
          rep_ch = $urandom_range(0, 1) ? ASC_F : ASC_0;
          rep_left = $urandom_range(2, 10);
        end
        if (rep_left > 0) begin
          ch = rep_ch;
          rep_left--;
        end else if ($urandom_range(0, 9) < 7) begin
          d = $urandom_range(0, 15);
          ch = 8'((d < 10) ? ASC_0 + d : ASC_A + d - 10);
        end else begin
          ch = 8'($urandom_range(0, 255));
        end
        queue_char(ch, i == len - 1);
      end
      left -= len;
    end
  endtask

  // Wait until every request is taken and every report entry has come out
  task automatic wait_idle();
    @(posedge clk);
    while (char_q.size() != 0 || in_valid || report_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [14:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    thr_cfg = v;
    @(posedge clk);
  endtask

  // Run limit
  initial begin : run_limit
    #40_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    string dir_chars;
    thr_cfg = THR_RESET;
    clear_key_stats();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty key, every digit, boundary and ignored codes, byte extremes
    queue_char(ASC_X, 1'b1);
    dir_chars = "0123456789ABCDEF/:@Ga";
    for (int i = 0; i < dir_chars.len(); i++) queue_char(dir_chars[i], 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(ASC_F, 1'b1);
    wait_idle();

    // Zero threshold: every run is long
    write_threshold(15'd0);
    queue_random_keys(60);
    wait_idle();

    // Alternating bits: every run has length one and counts as long
    write_threshold(15'd1);
    queue_repeat_key(ASC_5, 40);
    wait_idle();

    // All ones: a single run that stays under the largest threshold
    write_threshold(CNT15_MAX);
    queue_repeat_key(ASC_F, 40);
    queue_random_keys(20);
    wait_idle();

    // Mid threshold, receiver holds off long enough to back up the input
    write_threshold(15'($urandom_range(2, 40)));
    hold_req = 1'b1;
    queue_random_keys(130);
    wait_idle();

    // Last stretch runs without idling on either side
    write_threshold(15'($urandom_range(1, 12)));
    no_idle = 1'b1;
    queue_random_keys(130);
    wait_idle();
    repeat (32) @(posedge clk);

    if (err_cnt == 0 && report_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/rngst_pkg.sv
design/rng_statistical_test_suite.sv
design/rngst_checker.sv
bench/tb.sv
